// ----- src/oest_pkg.sv -----
// Shared types and constants for the overlap enter/stay/exit tracker.
`default_nettype none

package oest_pkg;

   // Storage geometry
   localparam int MAX_ENTRIES = 32;
   localparam int ID_BITS     = 16;
   localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);

   // Transaction field widths
   localparam int FUNC_W   = 2;
   localparam int OBJ_ID_W = 16;
   localparam int KIND_W   = 2;
   localparam int COUNT_W  = 6;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_TOUCH     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FRAME_END = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 2'd2;

   // Event kinds
   localparam logic [KIND_W-1:0] KIND_BEGIN    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CONTINUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END      = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [OBJ_ID_W-1:0] object_id;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]   event_kind;
      logic [OBJ_ID_W-1:0] event_id;
      logic [OBJ_ID_W-1:0] first_id;
      logic [COUNT_W-1:0]  entry_count;
      logic                last_of_run;
   } rsp_item_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_COMPARE,
      OP_TOUCH,
      OP_SCAN_START,
      OP_SCAN_NEXT,
      OP_SCAN_GRAB,
      OP_SCAN_REMOVE,
      OP_CONT_EMIT,
      OP_CLEAR_FLAGS
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rd_last;   // read port addresses the last entry instead of the pointer
   } dp_cmd_type;

   typedef struct packed {
      logic id_zero;
      logic empty;
      logic flag_rd;
      logic ptr_zero;
      logic last_zero;
      logic cont_last;
   } dp_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_T_CMP,
      ST_T_ACT,
      ST_F_START,
      ST_F_READ,
      ST_F_MOVE,
      ST_F_CONT,
      ST_F_DONE
   } ctrl_state_type;

endpackage

`default_nettype wire

// ----- src/overlap_enter_stay_exit_tracker.sv -----
// Top level of the overlap enter/stay/exit tracker.
`default_nettype none

// A transaction is taken when start is high and busy is low; results leave
// on rsp_item for one cycle each, marked by rsp_strobe, and cannot be held
// off. A touch runs a capture, a parallel id compare over all entries and an
// update, and gives at most one result; a touch with a zero id stops after
// the compare. A frame end is paced by the single read port of the entry
// list, which the scan walks one entry at a time, from the last entry down,
// and then the continue pass walks up. Results of one transaction come out
// in order and the final one carries last_of_run.

module overlap_enter_stay_exit_tracker
   import oest_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire req_item_type req_item,
   output logic              busy,
   output logic              rsp_strobe,
   output rsp_item_type      rsp_item
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequence each transaction
   oest_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_item.func),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   // Hold entries and build results
   oest_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_id     (req_item.object_id),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// ----- src/oest_dp.sv -----
// Datapath: entry list, touched flags, id compare and result register.
`default_nettype none

module oest_dp
   import oest_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   input  wire logic [OBJ_ID_W-1:0] req_id,
   output dp_stat_type              stat,
   output logic                     rsp_strobe,
   output rsp_item_type             rsp_item
);

   logic [ID_BITS-1:0]     ids_ff [MAX_ENTRIES];
   logic [ID_BITS-1:0]     ids_in [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] flags_ff, flags_in;
   logic [MAX_ENTRIES-1:0] match_ff, match_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [IDX_BITS-1:0]    ptr_ff, ptr_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic [ID_BITS-1:0]     gone_ff, gone_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_ff, rsp_in;

   logic [MAX_ENTRIES-1:0] valid_mask;
   logic [CNT_BITS-1:0]    last_cnt;
   logic [IDX_BITS-1:0]    last_idx;
   logic [IDX_BITS-1:0]    rd_addr;
   logic [ID_BITS-1:0]     rd_id;
   logic                   rd_flag;

   // Mark entries that hold a live id
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         valid_mask[i] = CNT_BITS'(i) < count_ff;
      end
   end

   // Select the single read port address
   assign last_cnt = count_ff - 1'b1;
   assign last_idx = last_cnt[IDX_BITS-1:0];
   assign rd_addr  = cmd.rd_last ? last_idx : ptr_ff;
   assign rd_id    = ids_ff[rd_addr];
   assign rd_flag  = flags_ff[rd_addr];

   // Report status to the controller
   always_comb begin
      stat.id_zero   = id_ff == '0;
      stat.empty     = count_ff == '0;
      stat.flag_rd   = rd_flag;
      stat.ptr_zero  = ptr_ff == '0;
      stat.last_zero = last_cnt == '0;
      stat.cont_last = CNT_BITS'(ptr_ff) == last_cnt;
   end

   // Execute the commanded operation
   always_comb begin
      ids_in       = ids_ff;
      flags_in     = flags_ff;
      match_in     = match_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      id_in        = id_ff;
      gone_in      = gone_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (cmd.op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            id_in = req_id[ID_BITS-1:0];
         end
         OP_COMPARE: begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               match_in[i] = valid_mask[i] && (ids_ff[i] == id_ff);
            end
         end
         OP_TOUCH: begin
            if (|match_ff) begin
               flags_in = flags_ff | match_ff;
            end else if (count_ff == CNT_BITS'(MAX_ENTRIES)) begin
               rsp_valid_in       = 1'b1;
               rsp_in.event_kind  = KIND_OVERFLOW;
               rsp_in.event_id    = OBJ_ID_W'(id_ff);
               rsp_in.first_id    = OBJ_ID_W'(ids_ff[0]);
               rsp_in.entry_count = COUNT_W'(count_ff);
               rsp_in.last_of_run = 1'b1;
            end else begin
               ids_in[count_ff[IDX_BITS-1:0]]   = id_ff;
               flags_in[count_ff[IDX_BITS-1:0]] = 1'b1;
               count_in           = count_ff + 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_in.event_kind  = KIND_BEGIN;
               rsp_in.event_id    = OBJ_ID_W'(id_ff);
               rsp_in.first_id    = (count_ff == '0) ? OBJ_ID_W'(id_ff)
                                                     : OBJ_ID_W'(ids_ff[0]);
               rsp_in.entry_count = COUNT_W'(count_ff + 1'b1);
               rsp_in.last_of_run = 1'b1;
            end
         end
         OP_SCAN_START: begin
            ptr_in = last_idx;
         end
         OP_SCAN_NEXT: begin
            ptr_in = ptr_ff - 1'b1;
         end
         OP_SCAN_GRAB: begin
            gone_in = rd_id;
         end
         OP_SCAN_REMOVE: begin
            // rd_id / rd_flag hold the last entry here
            ids_in[ptr_ff]     = rd_id;
            flags_in[ptr_ff]   = rd_flag;
            flags_in[last_idx] = 1'b0;
            count_in           = last_cnt;
            if (ptr_ff != '0) begin
               ptr_in = ptr_ff - 1'b1;
            end
            rsp_valid_in       = 1'b1;
            rsp_in.event_kind  = KIND_END;
            rsp_in.event_id    = OBJ_ID_W'(gone_ff);
            if (last_cnt == '0) begin
               rsp_in.first_id = '0;
            end else if (ptr_ff == '0) begin
               rsp_in.first_id = OBJ_ID_W'(rd_id);
            end else begin
               rsp_in.first_id = OBJ_ID_W'(ids_ff[0]);
            end
            rsp_in.entry_count = COUNT_W'(last_cnt);
            rsp_in.last_of_run = last_cnt == '0;
         end
         OP_CONT_EMIT: begin
            ptr_in             = ptr_ff + 1'b1;
            rsp_valid_in       = 1'b1;
            rsp_in.event_kind  = KIND_CONTINUE;
            rsp_in.event_id    = OBJ_ID_W'(rd_id);
            rsp_in.first_id    = OBJ_ID_W'(ids_ff[0]);
            rsp_in.entry_count = COUNT_W'(count_ff);
            rsp_in.last_of_run = CNT_BITS'(ptr_ff) == last_cnt;
         end
         OP_CLEAR_FLAGS: begin
            flags_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         match_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flags_ff     <= flags_in;
         match_ff     <= match_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      ids_ff  <= ids_in;
      ptr_ff  <= ptr_in;
      id_ff   <= id_in;
      gone_ff <= gone_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_ENTRIES))
      else $error("entry count exceeds capacity");

   a_flags_live: assert property (@(posedge clock) disable iff (reset)
      (flags_ff & ~valid_mask) == '0)
      else $error("touched flag set beyond live entries");

   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_ff))
      else $error("id matches more than one entry");

endmodule

`default_nettype wire

// ----- src/oest_ctrl.sv -----
// Controller: sequences touch, flag clear, frame-end scan and continue passes.
`default_nettype none

module oest_ctrl
   import oest_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire dp_stat_type       stat,
   output logic                   busy,
   output dp_cmd_type             cmd
);

   ctrl_state_type state_ff, state_in;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode next state and datapath commands
   always_comb begin
      state_in    = state_ff;
      cmd.op      = OP_NOP;
      cmd.rd_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_func)
                  FUNC_TOUCH: begin
                     cmd.op   = OP_LOAD;
                     state_in = ST_T_CMP;
                  end
                  FUNC_FRAME_END: begin
                     state_in = ST_F_START;
                  end
                  FUNC_CLEAR: begin
                     cmd.op = OP_CLEAR_FLAGS;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_T_CMP: begin
            cmd.op   = OP_COMPARE;
            state_in = stat.id_zero ? ST_IDLE : ST_T_ACT;
         end
         ST_T_ACT: begin
            cmd.op   = OP_TOUCH;
            state_in = ST_IDLE;
         end
         ST_F_START: begin
            if (stat.empty) begin
               state_in = ST_F_DONE;
            end else begin
               cmd.op   = OP_SCAN_START;
               state_in = ST_F_READ;
            end
         end
         ST_F_READ: begin
            priority if (!stat.flag_rd) begin
               cmd.op   = OP_SCAN_GRAB;
               state_in = ST_F_MOVE;
            end else if (stat.ptr_zero) begin
               state_in = ST_F_CONT;
            end else begin
               cmd.op = OP_SCAN_NEXT;
            end
         end
         ST_F_MOVE: begin
            cmd.op      = OP_SCAN_REMOVE;
            cmd.rd_last = 1'b1;
            priority if (!stat.ptr_zero) begin
               state_in = ST_F_READ;
            end else if (stat.last_zero) begin
               state_in = ST_F_DONE;
            end else begin
               state_in = ST_F_CONT;
            end
         end
         ST_F_CONT: begin
            cmd.op = OP_CONT_EMIT;
            if (stat.cont_last) begin
               state_in = ST_F_DONE;
            end
         end
         ST_F_DONE: begin
            cmd.op   = OP_CLEAR_FLAGS;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;

   a_move_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_F_MOVE) |-> ($past(state_ff) == ST_F_READ))
      else $error("removal entered without a scan read");

   a_touch_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_TOUCH) |=> (state_ff == ST_T_CMP))
      else $error("accepted touch did not start a compare");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the overlap enter/stay/exit tracker: directed table, fill sweep, random frames.
`timescale 1ns / 1ps

module tb;
   import oest_pkg::*;

   // Selector value that the block ignores
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // How a directed row gets its expected results
   localparam logic [1:0] ROW_PREDICT   = 2'd0;
   localparam logic [1:0] ROW_NO_EVENT  = 2'd1;
   localparam logic [1:0] ROW_ONE_EVENT = 2'd2;

   localparam int POOL_SIZE    = 48;
   localparam int RANDOM_ITEMS = 150;
   localparam int GAP_MAX      = 17;
   localparam int FLOOD_LEN    = MAX_ENTRIES + 4;
   localparam int DRAIN_BOUND  = 4000;
   localparam int DRAIN_CYCLES = 160;

   localparam rsp_item_type NO_RSP = '0;

   typedef struct packed {
      req_item_type item;
      logic [1:0]   mode;
      rsp_item_type ev;
   } dir_row_type;

   // Directed rows: empty cases, extreme ids, repeats, removal and re-touch after a clear
   localparam dir_row_type DIR_ROWS [18] = '{
      '{'{FUNC_TOUCH,     16'h0000}, ROW_NO_EVENT,  NO_RSP},
      '{'{FUNC_FRAME_END, 16'h0000}, ROW_NO_EVENT,  NO_RSP},
      '{'{FUNC_UNUSED,    16'hA5C3}, ROW_NO_EVENT,  NO_RSP},
      '{'{FUNC_CLEAR,     16'hFFFF}, ROW_NO_EVENT,  NO_RSP},
      '{'{FUNC_TOUCH,     16'h0001}, ROW_ONE_EVENT,
        '{KIND_BEGIN, 16'h0001, 16'h0001, 6'd1, 1'b1}},
      '{'{FUNC_TOUCH,     16'h0001}, ROW_NO_EVENT,  NO_RSP},
      '{'{FUNC_TOUCH,     16'hFFFF}, ROW_ONE_EVENT,
        '{KIND_BEGIN, 16'hFFFF, 16'h0001, 6'd2, 1'b1}},
      '{'{FUNC_TOUCH,     16'h8000}, ROW_ONE_EVENT,
        '{KIND_BEGIN, 16'h8000, 16'h0001, 6'd3, 1'b1}},
      '{'{FUNC_FRAME_END, 16'h0000}, ROW_PREDICT,   NO_RSP},
      '{'{FUNC_TOUCH,     16'h0001}, ROW_NO_EVENT,  NO_RSP},
      '{'{FUNC_FRAME_END, 16'h0000}, ROW_PREDICT,   NO_RSP},
      '{'{FUNC_CLEAR,     16'h0000}, ROW_NO_EVENT,  NO_RSP},
      '{'{FUNC_FRAME_END, 16'h1234}, ROW_ONE_EVENT,
        '{KIND_END, 16'h0001, 16'h0000, 6'd0, 1'b1}},
      '{'{FUNC_TOUCH,     16'h7FFF}, ROW_ONE_EVENT,
        '{KIND_BEGIN, 16'h7FFF, 16'h7FFF, 6'd1, 1'b1}},
      '{'{FUNC_CLEAR,     16'h0000}, ROW_NO_EVENT,  NO_RSP},
      '{'{FUNC_TOUCH,     16'h7FFF}, ROW_NO_EVENT,  NO_RSP},
      '{'{FUNC_FRAME_END, 16'h0000}, ROW_PREDICT,   NO_RSP},
      '{'{FUNC_FRAME_END, 16'h0000}, ROW_ONE_EVENT,
        '{KIND_END, 16'h7FFF, 16'h0000, 6'd0, 1'b1}}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   req_item_type req_item = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   // Tracker image kept by the testbench
   logic [OBJ_ID_W-1:0] trk_ids [MAX_ENTRIES];
   logic                trk_touched [MAX_ENTRIES];
   int                  trk_count = 0;

   rsp_item_type fresh_events[$];
   rsp_item_type pending_events[$];

   int unsigned fail_count = 0;
   int unsigned items_sent = 0;
   int unsigned kind_seen [4] = '{0, 0, 0, 0};
   bit          quiet = 1'b0;
   logic [OBJ_ID_W-1:0] id_pool [POOL_SIZE];

   overlap_enter_stay_exit_tracker uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Build one event with the list head and count as they stand now
   function automatic rsp_item_type make_event(logic [KIND_W-1:0] kind,
                                               logic [OBJ_ID_W-1:0] id);
      rsp_item_type ev;
      ev.event_kind  = kind;
      ev.event_id    = id;
      ev.first_id    = (trk_count > 0) ? trk_ids[0] : '0;
      ev.entry_count = COUNT_W'(trk_count);
      ev.last_of_run = 1'b0;
      return ev;
   endfunction

   // Advance the tracker image by one transaction and collect its events
   function automatic void predict_events(req_item_type it);
      logic [OBJ_ID_W-1:0] gone;
      int                  last;
      bit                  found;
      rsp_item_type        tail;
      fresh_events.delete();
      case (it.func)
         FUNC_TOUCH: begin
            if (it.object_id != '0) begin
               found = 1'b0;
               for (int i = 0; i < trk_count; i++) begin
                  if (trk_ids[i] == it.object_id) begin
                     trk_touched[i] = 1'b1;
                     found = 1'b1;
                  end
               end
               if (!found && trk_count >= MAX_ENTRIES) begin
                  fresh_events.push_back(make_event(KIND_OVERFLOW, it.object_id));
               end else if (!found) begin
                  trk_ids[trk_count]     = it.object_id;
                  trk_touched[trk_count] = 1'b1;
                  trk_count++;
                  fresh_events.push_back(make_event(KIND_BEGIN, it.object_id));
               end
            end
         end
         FUNC_FRAME_END: begin
            // Drop untouched entries from the back, filling each hole with the last entry
            for (int i = trk_count; i > 0; i--) begin
               if (!trk_touched[i-1]) begin
                  gone               = trk_ids[i-1];
                  last               = trk_count - 1;
                  trk_ids[i-1]       = trk_ids[last];
                  trk_touched[i-1]   = trk_touched[last];
                  trk_touched[last]  = 1'b0;
                  trk_count          = last;
                  fresh_events.push_back(make_event(KIND_END, gone));
               end
            end
            for (int i = 0; i < trk_count; i++)
               fresh_events.push_back(make_event(KIND_CONTINUE, trk_ids[i]));
            foreach (trk_touched[i]) trk_touched[i] = 1'b0;
         end
         FUNC_CLEAR: begin
            foreach (trk_touched[i]) trk_touched[i] = 1'b0;
         end
         default: ;
      endcase
      // Mark the final event of the transaction
      if (fresh_events.size() > 0) begin
         tail = fresh_events.pop_back();
         tail.last_of_run = 1'b1;
         fresh_events.push_back(tail);
      end
   endfunction

   // Present one transaction after a random gap (none when quiet), then queue its expected events
   task automatic send_item(input req_item_type it, input logic [1:0] mode,
                            input rsp_item_type ev);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_events(it);
      if (mode == ROW_PREDICT) begin
         foreach (fresh_events[i]) pending_events.push_back(fresh_events[i]);
      end else if (mode == ROW_ONE_EVENT) begin
         pending_events.push_back(ev);
      end
      items_sent++;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Compare each strobed result with the oldest expected event
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (pending_events.size() == 0) begin
            $error("unexpected result: kind %0d id 'h%0h", rsp_item.event_kind,
                   rsp_item.event_id);
            fail_count++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_kind",  want.event_kind,  rsp_item.event_kind);
            check_field("event_id",    want.event_id,    rsp_item.event_id);
            check_field("first_id",    want.first_id,    rsp_item.first_id);
            check_field("entry_count", want.entry_count, rsp_item.entry_count);
            check_field("last_of_run", want.last_of_run, rsp_item.last_of_run);
            kind_seen[rsp_item.event_kind]++;
         end
      end
   end

   // Stimulus
   initial begin
      req_item_type it;
      int unsigned  rand_done;
      int unsigned  frame_no;
      int unsigned  n_touch;
      int unsigned  pick;
      int unsigned  base;
      rand_done = 0;
      frame_no  = 0;
      foreach (trk_touched[i]) trk_touched[i] = 1'b0;
      foreach (trk_ids[i]) trk_ids[i] = '0;
      // Distinct nonzero ids: low bits carry the index
      foreach (id_pool[i]) id_pool[i] = {10'($urandom), 6'(i + 1)};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (DIR_ROWS[r]) send_item(DIR_ROWS[r].item, DIR_ROWS[r].mode, DIR_ROWS[r].ev);

      // Fill the list, overflow it, keep all, then drop all
      for (int i = 0; i < MAX_ENTRIES; i++)
         send_item(req_item_type'{FUNC_TOUCH, 16'((i + 1) * 16'h0801)}, ROW_PREDICT, NO_RSP);
      send_item(req_item_type'{FUNC_TOUCH, 16'hBEEF}, ROW_PREDICT, NO_RSP);
      send_item(req_item_type'{FUNC_TOUCH, 16'h0801}, ROW_PREDICT, NO_RSP);
      send_item(req_item_type'{FUNC_FRAME_END, 16'h0000}, ROW_PREDICT, NO_RSP);
      send_item(req_item_type'{FUNC_FRAME_END, 16'h0000}, ROW_PREDICT, NO_RSP);

      // Random frames: 0-6 touches then a frame end with noise mixed in, or a flood past capacity
      while (rand_done < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         frame_no++;
         if (frame_no == 6) begin
            // Hold off until every expected event has come out
            start <= 1'b0;
            @(posedge clock);
            while (pending_events.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 9) == 0) begin
            base = $urandom_range(0, POOL_SIZE - 1);
            for (int j = 0; j < FLOOD_LEN; j++) begin
               send_item(req_item_type'{FUNC_TOUCH, id_pool[(base + j) % POOL_SIZE]},
                         ROW_PREDICT, NO_RSP);
               rand_done++;
            end
            send_item(req_item_type'{FUNC_FRAME_END, 16'($urandom)}, ROW_PREDICT, NO_RSP);
            rand_done++;
         end else begin
            n_touch = $urandom_range(0, 6);
            for (int j = 0; j < n_touch; j++) begin
               pick = $urandom_range(0, 19);
               if (pick < 15)
                  it = '{FUNC_TOUCH, id_pool[$urandom_range(0, 15)]};
               else if (pick < 17)
                  it = '{FUNC_TOUCH, 16'($urandom)};
               else if (pick == 17)
                  it = '{FUNC_TOUCH, 16'h0000};
               else if (pick == 18)
                  it = '{FUNC_CLEAR, 16'($urandom)};
               else
                  it = '{FUNC_UNUSED, 16'($urandom)};
               send_item(it, ROW_PREDICT, NO_RSP);
               if (it.func != FUNC_UNUSED && !(it.func == FUNC_TOUCH && it.object_id == '0))
                  rand_done++;
            end
            // Leave out the frame end now and then so frames run together
            if ($urandom_range(0, 7) != 0) begin
               send_item(req_item_type'{FUNC_FRAME_END, 16'($urandom)}, ROW_PREDICT, NO_RSP);
               rand_done++;
            end
         end
      end
      start <= 1'b0;

      // Drain outstanding events, then watch for stray results
      for (int c = 0; c < DRAIN_BOUND && pending_events.size() != 0; c++) @(posedge clock);
      if (pending_events.size() != 0) begin
         $error("%0d expected events never arrived", pending_events.size());
         fail_count++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d transactions (table, full-list sweep, %0d random frames).",
               items_sent, frame_no);
      $display("Results checked: %0d begin, %0d continue, %0d end, %0d overflow.",
               kind_seen[KIND_BEGIN], kind_seen[KIND_CONTINUE], kind_seen[KIND_END],
               kind_seen[KIND_OVERFLOW]);
      if (fail_count == 0)
         $display("** overlap_enter_stay_exit_tracker: PASSED **");
      else
         $display("** overlap_enter_stay_exit_tracker: FAILED **");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("** overlap_enter_stay_exit_tracker: FAILED **");
      $finish;
   end

endmodule
